// ===== design/bgpt_pkg.sv =====
// ----------------------------------------------------------------------------
// bgpt_pkg
// Shared types and constants for the power button gesture detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bgpt_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned CfgIdxW = 8;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_CLICK_MIN  = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_CLICK_MAX  = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_DOUBLE_GAP = 8'd3;

  localparam logic [CfgW-1:0] LONG_PRESS_RST = 16'd2800;
  localparam logic [CfgW-1:0] CLICK_MIN_RST  = 16'd50;
  localparam logic [CfgW-1:0] CLICK_MAX_RST  = 16'd500;
  localparam logic [CfgW-1:0] DOUBLE_GAP_RST = 16'd500;

  localparam logic LEVEL_DOWN = 1'b0;
  localparam logic LEVEL_UP   = 1'b1;

  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_LONG   = 2'd1,
    GEST_FIRST  = 2'd2,
    GEST_DOUBLE = 2'd3
  } gesture_e;

  typedef struct packed {
    logic [CfgW-1:0] long_press_ms;
    logic [CfgW-1:0] click_min_ms;
    logic [CfgW-1:0] click_max_ms;
    logic [CfgW-1:0] double_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic     pwr_state;
    gesture_e gesture;
  } result_t;

endpackage

`default_nettype wire

// ===== design/bgpt_if.sv =====
// ----------------------------------------------------------------------------
// bgpt_in_if / bgpt_out_if
// Valid/ready channels for button samples and gesture results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bgpt_in_if;
  logic        valid;
  logic        ready;
  logic        button_level;
  logic [31:0] now_ms;

  modport source (output valid, output button_level, output now_ms, input ready);
  modport sink   (input valid, input button_level, input now_ms, output ready);
endinterface

interface bgpt_out_if;
  logic       valid;
  logic       ready;
  logic       pwr_state;
  logic [1:0] gesture;

  modport source (output valid, output pwr_state, output gesture, input ready);
  modport sink   (input valid, input pwr_state, input gesture, output ready);
endinterface

`default_nettype wire

// ===== design/bgpt_core.sv =====
// ----------------------------------------------------------------------------
// bgpt_core
// Gesture state and decision logic, evaluated once per sample.
// ----------------------------------------------------------------------------
`default_nettype none

module bgpt_core
  import bgpt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             level_i,
  input  wire logic [TimeW-1:0] now_i,
  input  wire cfg_t             cfg_i,
  output result_t               result_o
);

  logic             last_q, last_d;
  logic             power_q, power_d;
  logic [TimeW-1:0] mark_q, mark_d;
  logic             pending_q, pending_d;
  logic [TimeW-1:0] elapsed;
  logic             is_long, is_click;
  gesture_e         gest;

  // Modulo-2^32 difference handles counter wrap for free.
  assign elapsed  = now_i - mark_q;
  assign is_long  = elapsed >= {{(TimeW-CfgW){1'b0}}, cfg_i.long_press_ms};
  assign is_click = (elapsed > {{(TimeW-CfgW){1'b0}}, cfg_i.click_min_ms}) &&
                    (elapsed < {{(TimeW-CfgW){1'b0}}, cfg_i.click_max_ms});

  always_comb begin
    last_d    = last_q;
    power_d   = power_q;
    mark_d    = mark_q;
    pending_d = pending_q;
    gest      = GEST_NONE;
    if (level_i != last_q) begin
      last_d = level_i;
      if (level_i == LEVEL_DOWN) begin
        if (pending_q && (elapsed > {{(TimeW-CfgW){1'b0}}, cfg_i.double_gap_ms})) begin
          pending_d = 1'b0;
        end
        mark_d = now_i;
      end else begin
        // The long press test wins over an overlapping click window.
        priority if (is_long) begin
          mark_d  = '0;
          power_d = ~power_q;
          gest    = GEST_LONG;
        end else if (is_click) begin
          if (!pending_q) begin
            pending_d = 1'b1;
            mark_d    = now_i;
            gest      = GEST_FIRST;
          end else begin
            pending_d = 1'b0;
            mark_d    = '0;
            gest      = GEST_DOUBLE;
          end
        end else begin
          // A hold outside every window only updates the position.
          gest = GEST_NONE;
        end
      end
    end
  end

  assign result_o.pwr_state = power_d;
  assign result_o.gesture   = gest;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= LEVEL_DOWN;
      power_q   <= 1'b0;
      mark_q    <= '0;
      pending_q <= 1'b0;
    end else if (en_i) begin
      last_q    <= last_d;
      power_q   <= power_d;
      mark_q    <= mark_d;
      pending_q <= pending_d;
    end
  end

  a_long_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && gest == GEST_LONG) |=> (power_q != $past(power_q)))
    else $error("long press did not toggle power");

  a_power_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && gest != GEST_LONG) |=> (power_q == $past(power_q)))
    else $error("power changed without a long press");

  a_double_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && gest == GEST_DOUBLE) |=> (!pending_q && mark_q == '0))
    else $error("double click left state behind");

  a_first_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && gest == GEST_FIRST) |=> pending_q)
    else $error("first click did not set pending");

endmodule

`default_nettype wire

// ===== design/button_gesture_power_toggle.sv =====
// ----------------------------------------------------------------------------
// button_gesture_power_toggle
// Long press and double click detector driving a power state toggle.
// ----------------------------------------------------------------------------
// Samples pass the input register, then results pass the result register.
// Throughput: one sample per cycle unless the output side stalls; the input
// register and the state update run in a single pass, with the result
// register decoupling the output side. Reset: power off, button position
// pressed, mark cleared, no click pending, configuration registers at their default thresholds.
`default_nettype none

module button_gesture_power_toggle
  import bgpt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  bgpt_in_if.sink                 in_i,
  bgpt_out_if.source              out_o
);

  cfg_t             cfg_q;
  logic             in_valid_q;
  logic             level_q;
  logic [TimeW-1:0] now_q;
  logic             out_valid_q;
  result_t          out_q;
  result_t          result;
  logic             advance;

  // The sample in the input register moves on whenever the result slot is
  // free or is being emptied in this cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ms <= LONG_PRESS_RST;
      cfg_q.click_min_ms  <= CLICK_MIN_RST;
      cfg_q.click_max_ms  <= CLICK_MAX_RST;
      cfg_q.double_gap_ms <= DOUBLE_GAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LONG_PRESS: cfg_q.long_press_ms <= cfg_data_i;
        CFG_CLICK_MIN:  cfg_q.click_min_ms  <= cfg_data_i;
        CFG_CLICK_MAX:  cfg_q.click_max_ms  <= cfg_data_i;
        CFG_DOUBLE_GAP: cfg_q.double_gap_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      level_q <= in_i.button_level;
      now_q   <= in_i.now_ms;
    end
  end

  bgpt_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .level_i  (level_q),
    .now_i    (now_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pwr_state = out_q.pwr_state;
  assign out_o.gesture   = out_q.gesture;

endmodule

`default_nettype wire
